// File: design/fock_two_electron_accumulate_top_macros.svh
// assertion macros for the two-electron fock build block
`ifndef FOCK_TWO_ELECTRON_ACCUMULATE_TOP_MACROS_SVH
`define FOCK_TWO_ELECTRON_ACCUMULATE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define FTEA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define FTEA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ftea_pkg.sv
// ----------------------------------------------------------------------------
// ftea_pkg
// shared types, widths and codes of the two-electron fock build block
// ----------------------------------------------------------------------------
package ftea_pkg;

	localparam int MAX_BASIS_DEF = 32;
	localparam int FUNC_W        = 5;
	localparam int CNT_W         = 6;
	localparam int DATA_W        = 32;
	localparam int ACC_W         = 48;
	localparam int PROD_W        = 64;
	localparam int DELTA_W       = 44;
	localparam int SUM_W         = 50;
	localparam int STEP_W        = 3;

	// command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ACC  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_IDX = 2'd1;
	localparam logic [1:0] STAT_SAT = 2'd2;

	// update sequence of one integral
	localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
	localparam logic [STEP_W-1:0] STEP_XCH   = 3'd2;
	localparam logic [STEP_W-1:0] STEP_LAST  = 3'd5;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [FUNC_W-1:0] func_a;
		logic [FUNC_W-1:0] func_b;
		logic [FUNC_W-1:0] func_c;
		logic [FUNC_W-1:0] func_d;
		logic [FUNC_W-1:0] shell_a;
		logic [FUNC_W-1:0] shell_b;
		logic [FUNC_W-1:0] shell_c;
		logic [FUNC_W-1:0] shell_d;
		logic signed [DATA_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] fock_value;
		logic [1:0]              status;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic              capture;
		logic              clr;
		logic              load;
		logic              acc_rd;
		logic              acc_wr;
		logic              rd_ab;
		logic              rd_ba;
		logic              rd_sum;
		logic [STEP_W-1:0] step;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       clr_last;
		logic       idx_ok;
		logic [1:0] cmd;
	} dp_stat_t;

endpackage

// File: design/ftea_ram.sv
// ----------------------------------------------------------------------------
// ftea_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module ftea_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/ftea_ctrl.sv
// ----------------------------------------------------------------------------
// ftea_ctrl
// sequencer: clearing pass, decode, six updates per integral, reads
// ----------------------------------------------------------------------------
module ftea_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  ftea_pkg::dp_stat_t  stat,
	output ftea_pkg::ctrl_cmd_t cmd
);

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_DECODE  = 4'd2;
	localparam logic [3:0] ST_LOAD    = 4'd3;
	localparam logic [3:0] ST_ACC_RD  = 4'd4;
	localparam logic [3:0] ST_ACC_MUL = 4'd5;
	localparam logic [3:0] ST_ACC_RND = 4'd6;
	localparam logic [3:0] ST_ACC_WR  = 4'd7;
	localparam logic [3:0] ST_RD_AB   = 4'd8;
	localparam logic [3:0] ST_RD_BA   = 4'd9;
	localparam logic [3:0] ST_RD_SUM  = 4'd10;
	localparam logic [3:0] ST_DONE    = 4'd11;

	logic [3:0]                  state_q, state_d;
	logic [ftea_pkg::STEP_W-1:0] step_q, step_d;

	// next state
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				step_d = ftea_pkg::STEP_FIRST;
				if (!stat.idx_ok) begin
					state_d = ST_DONE;
				end else begin
					case (stat.cmd)
						ftea_pkg::CMD_LOAD: state_d = ST_LOAD;
						ftea_pkg::CMD_ACC:  state_d = ST_ACC_RD;
						ftea_pkg::CMD_READ: state_d = ST_RD_AB;
						default:            state_d = ST_DONE;
					endcase
				end
			end
			ST_LOAD:    state_d = ST_DONE;
			ST_ACC_RD:  state_d = ST_ACC_MUL;
			ST_ACC_MUL: state_d = ST_ACC_RND;
			ST_ACC_RND: state_d = ST_ACC_WR;
			ST_ACC_WR: begin
				if (step_q == ftea_pkg::STEP_LAST) begin
					state_d = ST_DONE;
				end else begin
					step_d  = step_q + 1'b1;
					state_d = ST_ACC_RD;
				end
			end
			ST_RD_AB:  state_d = ST_RD_BA;
			ST_RD_BA:  state_d = ST_RD_SUM;
			ST_RD_SUM: state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.capture = (state_q == ST_IDLE) && start;
		cmd.clr     = (state_q == ST_CLEAR);
		cmd.load    = (state_q == ST_LOAD);
		cmd.acc_rd  = (state_q == ST_ACC_RD);
		cmd.acc_wr  = (state_q == ST_ACC_WR);
		cmd.rd_ab   = (state_q == ST_RD_AB);
		cmd.rd_ba   = (state_q == ST_RD_BA);
		cmd.rd_sum  = (state_q == ST_RD_SUM);
		cmd.step    = step_q;
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// File: design/ftea_dp.sv
// ----------------------------------------------------------------------------
// ftea_dp
// datapath: item registers, density and accumulator rams, multiply, round,
// saturating add and symmetrized read
// ----------------------------------------------------------------------------
module ftea_dp #(
	parameter int MAX_BASIS = ftea_pkg::MAX_BASIS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ftea_pkg::item_t                item,
	input  logic                           cfg_we,
	input  logic [ftea_pkg::CNT_W-1:0]     cfg_data,
	input  ftea_pkg::ctrl_cmd_t            cmd,
	output ftea_pkg::dp_stat_t             stat,
	output ftea_pkg::result_t              result
);

	localparam int DEPTH  = MAX_BASIS * MAX_BASIS;
	localparam int ADDR_W = $clog2(DEPTH);

	function automatic logic [ADDR_W-1:0] addr_of(
		input logic [ftea_pkg::FUNC_W-1:0] r,
		input logic [ftea_pkg::FUNC_W-1:0] c
	);
		addr_of = ADDR_W'(32'(r) * MAX_BASIS + 32'(c));
	endfunction

	ftea_pkg::item_t item_q;
	logic [ftea_pkg::CNT_W-1:0]        basis_count_q;
	logic [ADDR_W-1:0]                 clr_addr_q;
	logic [1:0]                        deg_k_q;
	logic                              sat_q;
	logic signed [ftea_pkg::ACC_W-1:0] value_q;
	logic signed [ftea_pkg::ACC_W-1:0] g_ab_q;
	logic signed [ftea_pkg::PROD_W-1:0]  prod_s1;
	logic signed [ftea_pkg::ACC_W-1:0]   acc_s1;
	logic signed [ftea_pkg::DELTA_W-1:0] delta_s2;

	logic [ftea_pkg::DATA_W-1:0] dens_rdata;
	logic [ftea_pkg::ACC_W-1:0]  fock_rdata;
	logic                        dens_we, fock_we, fock_re;
	logic [ADDR_W-1:0]           dens_waddr, dens_raddr, fock_waddr, fock_raddr;
	logic [ftea_pkg::ACC_W-1:0]  fock_wdata;

	logic [ftea_pkg::FUNC_W-1:0] tgt_r, tgt_c, den_r, den_c;
	logic                        ok_a, ok_b, ok_c, ok_d;
	logic [5:0]                  shamt;
	logic signed [ftea_pkg::PROD_W-1:0]  rnd_sum;
	logic signed [ftea_pkg::PROD_W-1:0]  rnd_shift;
	logic signed [ftea_pkg::DELTA_W-1:0] delta_d;
	logic signed [ftea_pkg::SUM_W-1:0]   acc_sum;
	logic signed [ftea_pkg::ACC_W-1:0]   acc_new;
	logic                                acc_clamp;
	logic signed [ftea_pkg::ACC_W:0]     rd_sum;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_count_q <= ftea_pkg::CNT_W'(32);
		end else if (cfg_we) begin
			basis_count_q <= cfg_data;
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// item capture and degeneracy exponent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q  <= '0;
			deg_k_q <= '0;
		end else if (cmd.capture) begin
			item_q  <= item;
			deg_k_q <= 2'(32'(item.shell_a != item.shell_b)
				+ 32'(item.shell_c != item.shell_d)
				+ 32'(!(item.shell_a == item.shell_c && item.shell_b == item.shell_d)));
		end
	end

	// index range checks
	always_comb begin
		ok_a = (32'(item_q.func_a) < 32'(basis_count_q)) && (32'(item_q.func_a) < MAX_BASIS);
		ok_b = (32'(item_q.func_b) < 32'(basis_count_q)) && (32'(item_q.func_b) < MAX_BASIS);
		ok_c = (32'(item_q.func_c) < 32'(basis_count_q)) && (32'(item_q.func_c) < MAX_BASIS);
		ok_d = (32'(item_q.func_d) < 32'(basis_count_q)) && (32'(item_q.func_d) < MAX_BASIS);
		case (item_q.cmd)
			ftea_pkg::CMD_LOAD, ftea_pkg::CMD_READ: stat.idx_ok = ok_a && ok_b;
			ftea_pkg::CMD_ACC: stat.idx_ok = ok_a && ok_b && ok_c && ok_d;
			default:           stat.idx_ok = 1'b1;
		endcase
		stat.cmd      = item_q.cmd;
		stat.clr_last = (clr_addr_q == ADDR_W'(DEPTH - 1));
	end

	// target and density entries of each update
	always_comb begin
		case (cmd.step)
			3'd0: begin
				tgt_r = item_q.func_a; tgt_c = item_q.func_b;
				den_r = item_q.func_c; den_c = item_q.func_d;
			end
			3'd1: begin
				tgt_r = item_q.func_c; tgt_c = item_q.func_d;
				den_r = item_q.func_a; den_c = item_q.func_b;
			end
			3'd2: begin
				tgt_r = item_q.func_a; tgt_c = item_q.func_c;
				den_r = item_q.func_b; den_c = item_q.func_d;
			end
			3'd3: begin
				tgt_r = item_q.func_b; tgt_c = item_q.func_d;
				den_r = item_q.func_a; den_c = item_q.func_c;
			end
			3'd4: begin
				tgt_r = item_q.func_a; tgt_c = item_q.func_d;
				den_r = item_q.func_b; den_c = item_q.func_c;
			end
			default: begin
				tgt_r = item_q.func_b; tgt_c = item_q.func_c;
				den_r = item_q.func_a; den_c = item_q.func_d;
			end
		endcase
	end

	// ram port selection
	always_comb begin
		dens_we    = cmd.load;
		dens_waddr = addr_of(item_q.func_a, item_q.func_b);
		dens_raddr = addr_of(den_r, den_c);
		fock_we    = cmd.clr || cmd.load || (cmd.acc_wr);
		fock_waddr = cmd.clr ? clr_addr_q
			: (cmd.load ? addr_of(item_q.func_a, item_q.func_b) : addr_of(tgt_r, tgt_c));
		fock_wdata = (cmd.clr || cmd.load) ? '0 : acc_new;
		fock_re    = cmd.acc_rd || cmd.rd_ab || cmd.rd_ba;
		if (cmd.rd_ab) begin
			fock_raddr = addr_of(item_q.func_a, item_q.func_b);
		end else if (cmd.rd_ba) begin
			fock_raddr = addr_of(item_q.func_b, item_q.func_a);
		end else begin
			fock_raddr = addr_of(tgt_r, tgt_c);
		end
	end

	ftea_ram #(.WIDTH(ftea_pkg::DATA_W), .DEPTH(DEPTH)) u_dens_ram (
		.clk   (clk),
		.we    (dens_we),
		.waddr (dens_waddr),
		.wdata (item_q.sample),
		.re    (cmd.acc_rd),
		.raddr (dens_raddr),
		.rdata (dens_rdata)
	);

	ftea_ram #(.WIDTH(ftea_pkg::ACC_W), .DEPTH(DEPTH)) u_fock_ram (
		.clk   (clk),
		.we    (fock_we),
		.waddr (fock_waddr),
		.wdata (fock_wdata),
		.re    (fock_re),
		.raddr (fock_raddr),
		.rdata (fock_rdata)
	);

	// stage 1: integral times density, old accumulator
	always_ff @(posedge clk) begin
		prod_s1 <= item_q.sample * $signed(dens_rdata);
		acc_s1  <= $signed(fock_rdata);
	end

	// stage 2: degeneracy scale and round to nearest, ties up, negated on exchange steps
	always_comb begin
		shamt     = (cmd.step >= ftea_pkg::STEP_XCH) ? 6'(26 - 32'(deg_k_q))
			: 6'(24 - 32'(deg_k_q));
		rnd_sum   = prod_s1 + (64'sd1 <<< (shamt - 6'd1));
		rnd_shift = rnd_sum >>> shamt;
		delta_d   = (cmd.step >= ftea_pkg::STEP_XCH) ? -rnd_shift[ftea_pkg::DELTA_W-1:0]
			: rnd_shift[ftea_pkg::DELTA_W-1:0];
	end

	always_ff @(posedge clk) begin
		delta_s2 <= delta_d;
	end

	// saturating accumulate
	always_comb begin
		acc_sum   = ftea_pkg::SUM_W'(acc_s1) + ftea_pkg::SUM_W'(delta_s2);
		acc_clamp = 1'b0;
		acc_new   = acc_sum[ftea_pkg::ACC_W-1:0];
		if (acc_sum > $signed(ftea_pkg::SUM_W'(48'h7FFF_FFFF_FFFF))) begin
			acc_new   = {1'b0, {(ftea_pkg::ACC_W-1){1'b1}}};
			acc_clamp = 1'b1;
		end else if (acc_sum < -$signed(ftea_pkg::SUM_W'(49'h0_8000_0000_0000))) begin
			acc_new   = {1'b1, {(ftea_pkg::ACC_W-1){1'b0}}};
			acc_clamp = 1'b1;
		end
	end

	// symmetrized read, halved toward minus infinity
	assign rd_sum = (ftea_pkg::ACC_W+1)'(g_ab_q) + (ftea_pkg::ACC_W+1)'($signed(fock_rdata));

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q   <= 1'b0;
			value_q <= '0;
			g_ab_q  <= '0;
		end else begin
			if (cmd.capture) begin
				sat_q   <= 1'b0;
				value_q <= '0;
			end
			if (cmd.acc_wr && acc_clamp) sat_q <= 1'b1;
			if (cmd.rd_ba) g_ab_q <= $signed(fock_rdata);
			if (cmd.rd_sum) value_q <= rd_sum[ftea_pkg::ACC_W:1];
		end
	end

	// result fields
	always_comb begin
		result.fock_value = value_q;
		if (!stat.idx_ok) begin
			result.status = ftea_pkg::STAT_IDX;
		end else if ((item_q.cmd == ftea_pkg::CMD_ACC) && sat_q) begin
			result.status = ftea_pkg::STAT_SAT;
		end else begin
			result.status = ftea_pkg::STAT_OK;
		end
	end

endmodule

// File: design/fock_two_electron_accumulate_top.sv
// ----------------------------------------------------------------------------
// fock_two_electron_accumulate_top
// two-electron fock build: density load, integral accumulate, symmetrized read
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all MAX_BASIS*MAX_BASIS
// accumulator entries (1024 by default) with busy high. From start to done,
// a load passes decode and a load state, a read decode and three read states,
// a rejected or unused command decode alone, and an integral six accumulator
// updates, each a read, multiply, round and write back; the next update may
// hit the same accumulator entry, so it reads only after that write. Done is
// high for one cycle with the result and cannot be held off; take it then.
`include "fock_two_electron_accumulate_top_macros.svh"

module fock_two_electron_accumulate_top #(
	parameter int MAX_BASIS = ftea_pkg::MAX_BASIS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  ftea_pkg::item_t            item,
	output logic                       done,
	output ftea_pkg::result_t          result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ftea_pkg::CNT_W-1:0] cfg_data
);

	ftea_pkg::ctrl_cmd_t ctrl_cmd;
	ftea_pkg::dp_stat_t  dp_stat;
	logic                idx_err;

	// configuration transfer always taken
	assign cfg_ready = 1'b1;

	ftea_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (dp_stat),
		.cmd    (ctrl_cmd)
	);

	ftea_dp #(.MAX_BASIS(MAX_BASIS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (ctrl_cmd),
		.stat     (dp_stat),
		.result   (result)
	);

	// index error flag for the checks
	assign idx_err = (result.status == ftea_pkg::STAT_IDX);

	// checks
	`FTEA_ASSERT_NOW(a_done_busy, done, busy, "done outside a busy command")
	`FTEA_ASSERT_NEXT(a_done_idle, done, !busy && !done, "done not followed by idle")
	`FTEA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command not busy")
	`FTEA_ASSERT_NOW(a_err_zero, done && idx_err, result.fock_value == '0, "error with a value")

endmodule
